[design/assert_macros.svh]
// Assertion macros shared by the angle pipeline RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SABV_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SABV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sabv_pkg.sv]
// Shared types, constants and the arctangent table for the vector angle pipeline.
`default_nettype none

package sabv_pkg;

    // Parameter defaults
    localparam int COORD_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;

    // Result format: Q2.13 radians
    localparam int ANGLE_W     = 16;
    localparam int OUT_PI      = 25736;
    localparam int ROUND_SHIFT = 11;
    localparam int ROUND_HALF  = 1024;

    // Normalized operands: larger magnitude in [2^48, 2^49)
    localparam int NORM_MSB = 48;
    localparam int NORM_W   = 50;
    localparam int SH_W     = 6;

    // CORDIC datapath widths (x/y with gain headroom, z in Q.24 radians)
    localparam int XY_W = 53;
    localparam int Z_W  = 28;

    localparam logic signed [Z_W-1:0] ACC_HALF_PI = 28'sd26353589;
    localparam logic signed [ANGLE_W-1:0] ANGLE_PI = 16'sd25736;
    localparam logic signed [ANGLE_W-1:0] ANGLE_NEG_PI = -16'sd25736;

    // Flags that ride along with each item
    typedef struct packed {
        logic zero_len;
        logic cross_zero;
        logic dot_neg;
        logic cross_neg;
    } side_t;

    // One finished result
    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic                      zero_len;
    } result_t;

    // atan(2^-i) in Q.24, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 28'sd13176795;
            1:       v = 28'sd7778716;
            2:       v = 28'sd4110060;
            3:       v = 28'sd2086331;
            4:       v = 28'sd1047214;
            5:       v = 28'sd524117;
            6:       v = 28'sd262123;
            7:       v = 28'sd131069;
            8:       v = 28'sd65536;
            9:       v = 28'sd32768;
            10:      v = 28'sd16384;
            11:      v = 28'sd8192;
            12:      v = 28'sd4096;
            13:      v = 28'sd2048;
            14:      v = 28'sd1024;
            15:      v = 28'sd512;
            16:      v = 28'sd256;
            17:      v = 28'sd128;
            18:      v = 28'sd64;
            19:      v = 28'sd32;
            20:      v = 28'sd16;
            21:      v = 28'sd8;
            22:      v = 28'sd4;
            23:      v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[design/sabv_norm.sv]
// Dot/cross products and block normalization ahead of the CORDIC (six stages).
`default_nettype none

module sabv_norm #(
    parameter int COORD_WIDTH = sabv_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [COORD_WIDTH-1:0]       first_x,
    input  logic signed [COORD_WIDTH-1:0]       first_y,
    input  logic signed [COORD_WIDTH-1:0]       second_x,
    input  logic signed [COORD_WIDTH-1:0]       second_y,
    output logic                                out_valid,
    output logic signed [sabv_pkg::NORM_W-1:0]  x_n,
    output logic signed [sabv_pkg::NORM_W-1:0]  y_n,
    output sabv_pkg::side_t                     side
);
    import sabv_pkg::*;

    localparam int PW     = 2 * COORD_WIDTH;        // product width
    localparam int DW     = PW + 1;                 // dot / cross width
    localparam int MW     = PW;                     // magnitude width
    localparam int NG     = (MW + 7) / 8;           // 8-bit groups for msb search
    localparam int MWP    = NG * 8;
    localparam int GI_W   = (NG > 1) ? $clog2(NG) : 1;
    localparam int MSB_W  = GI_W + 3;
    localparam int WIDE_W = DW + NORM_MSB;

    // Stage 1: products
    logic                 v1_reg, zl1_reg;
    logic signed [PW-1:0] pa_reg, pc_reg, pp_reg, pq_reg;

    // Stage 2: dot and cross
    logic                 v2_reg, zl2_reg;
    logic signed [DW-1:0] dot2_reg, cross2_reg;

    // Stage 3: flags and combined magnitude
    logic                 v3_reg;
    side_t                side3_reg;
    logic signed [DW-1:0] dot3_reg, cross3_reg;
    logic [MW-1:0]        mag3_reg;
    logic [DW-1:0]        dot_abs, cross_abs;

    // Stage 4: per-group leading-one
    logic                 v4_reg;
    side_t                side4_reg;
    logic signed [DW-1:0] dot4_reg, cross4_reg;
    logic [NG-1:0]        grp_any_reg, grp_any_next;
    logic [2:0]           grp_pos_reg [NG], grp_pos_next [NG];
    logic [MWP-1:0]       mag_pad;

    // Stage 5: shift amount
    logic                 v5_reg;
    side_t                side5_reg;
    logic signed [DW-1:0] dot5_reg, cross5_reg;
    logic [SH_W-1:0]      sh_left_reg, sh_left_next, sh_right_reg, sh_right_next;
    logic                 sh_rsel_reg, sh_rsel_next;
    logic [MSB_W-1:0]     msb;

    // Stage 6: shifted operands
    logic                     v6_reg;
    side_t                    side6_reg;
    logic signed [NORM_W-1:0] xn_reg, yn_reg;
    logic signed [WIDE_W-1:0] dot_wide, cross_wide, dot_sh, cross_sh;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Magnitudes of dot and cross; both fit MW bits
    always_comb
    begin
        dot_abs   = dot2_reg[DW-1] ? DW'(-dot2_reg) : DW'(dot2_reg);
        cross_abs = cross2_reg[DW-1] ? DW'(-cross2_reg) : DW'(cross2_reg);
    end

    // Leading one inside each 8-bit group
    always_comb
    begin
        mag_pad = MWP'(mag3_reg);
        for (int g = 0; g < NG; g++)
        begin
            grp_any_next[g] = |mag_pad[g*8 +: 8];
            grp_pos_next[g] = 3'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (mag_pad[g*8 + b])
                begin
                    grp_pos_next[g] = 3'(b);
                end
            end
        end
    end

    // Highest nonzero group gives the msb, then the shift toward bit 48
    always_comb
    begin
        msb = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (grp_any_reg[g])
            begin
                msb = MSB_W'(g * 8) + MSB_W'(grp_pos_reg[g]);
            end
        end
        sh_rsel_next  = (int'(msb) > NORM_MSB);
        sh_right_next = sh_rsel_next ? SH_W'(int'(msb) - NORM_MSB) : '0;
        sh_left_next  = sh_rsel_next ? '0 : SH_W'(NORM_MSB - int'(msb));
    end

    // Floor right shift or left shift, same amount on both operands
    always_comb
    begin
        dot_wide   = WIDE_W'(dot5_reg);
        cross_wide = WIDE_W'(cross5_reg);
        dot_sh     = sh_rsel_reg ? (dot_wide >>> sh_right_reg) : (dot_wide <<< sh_left_reg);
        cross_sh   = sh_rsel_reg ? (cross_wide >>> sh_right_reg)
                                 : (cross_wide <<< sh_left_reg);
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zl1_reg <= ((first_x == '0) && (first_y == '0)) ||
                       ((second_x == '0) && (second_y == '0));
            pa_reg  <= first_x * second_x;
            pc_reg  <= first_y * second_y;
            pp_reg  <= first_x * second_y;
            pq_reg  <= first_y * second_x;

            zl2_reg    <= zl1_reg;
            dot2_reg   <= DW'(pa_reg) + DW'(pc_reg);
            cross2_reg <= DW'(pp_reg) - DW'(pq_reg);

            side3_reg.zero_len   <= zl2_reg;
            side3_reg.cross_zero <= (cross2_reg == '0);
            side3_reg.dot_neg    <= dot2_reg[DW-1];
            side3_reg.cross_neg  <= cross2_reg[DW-1];
            dot3_reg             <= dot2_reg;
            cross3_reg           <= cross2_reg;
            mag3_reg             <= dot_abs[MW-1:0] | cross_abs[MW-1:0];

            side4_reg   <= side3_reg;
            dot4_reg    <= dot3_reg;
            cross4_reg  <= cross3_reg;
            grp_any_reg <= grp_any_next;
            grp_pos_reg <= grp_pos_next;

            side5_reg    <= side4_reg;
            dot5_reg     <= dot4_reg;
            cross5_reg   <= cross4_reg;
            sh_left_reg  <= sh_left_next;
            sh_right_reg <= sh_right_next;
            sh_rsel_reg  <= sh_rsel_next;

            side6_reg <= side5_reg;
            xn_reg    <= dot_sh[NORM_W-1:0];
            yn_reg    <= cross_sh[NORM_W-1:0];
        end
    end

    assign out_valid = v6_reg;
    assign x_n       = xn_reg;
    assign y_n       = yn_reg;
    assign side      = side6_reg;

endmodule

`default_nettype wire

[design/sabv_cordic.sv]
// Vectoring CORDIC, one iteration per stage, then rounding and special cases.
`default_nettype none

module sabv_cordic #(
    parameter int CORDIC_STAGES = sabv_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [sabv_pkg::NORM_W-1:0]  x_n,
    input  logic signed [sabv_pkg::NORM_W-1:0]  y_n,
    input  sabv_pkg::side_t                     side,
    output logic                                out_valid,
    output sabv_pkg::result_t                   res
);
    import sabv_pkg::*;

    localparam int NSTG = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int RQ_W = Z_W - ROUND_SHIFT;

    // Stage arrays: index 0 is the quadrant pre-rotation
    logic                 cv_reg [NSTG+1];
    side_t                cs_reg [NSTG+1];
    logic signed [XY_W-1:0] cx_reg [NSTG+1];
    logic signed [XY_W-1:0] cy_reg [NSTG+1];
    logic signed [Z_W-1:0]  cz_reg [NSTG+1];

    logic signed [XY_W-1:0] xe, ye;

    // Rounding stages
    logic                 vr1_reg, vr2_reg;
    side_t                sr1_reg;
    logic [Z_W-1:0]       absz_reg, absz_next;
    logic [RQ_W-1:0]      rq;
    logic signed [ANGLE_W-1:0] mag_sat;
    result_t              res_reg, res_next;

    assign xe = XY_W'(x_n);
    assign ye = XY_W'(y_n);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSTG; k++)
            begin
                cv_reg[k] <= 1'b0;
            end
            vr1_reg <= 1'b0;
            vr2_reg <= 1'b0;
        end
        else if (en)
        begin
            cv_reg[0] <= in_valid;
            for (int k = 1; k <= NSTG; k++)
            begin
                cv_reg[k] <= cv_reg[k-1];
            end
            vr1_reg <= cv_reg[NSTG];
            vr2_reg <= vr1_reg;
        end
    end

    // Pre-rotation by +/- pi/2 when x is negative
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_reg[0] <= side;
            if (!xe[XY_W-1])
            begin
                cx_reg[0] <= xe;
                cy_reg[0] <= ye;
                cz_reg[0] <= '0;
            end
            else if (!ye[XY_W-1])
            begin
                cx_reg[0] <= ye;
                cy_reg[0] <= -xe;
                cz_reg[0] <= ACC_HALF_PI;
            end
            else
            begin
                cx_reg[0] <= -ye;
                cy_reg[0] <= xe;
                cz_reg[0] <= -ACC_HALF_PI;
            end
        end
    end

    // One micro-rotation per stage, driving y toward zero
    for (genvar i = 0; i < NSTG; i++)
    begin : g_iter
        logic signed [XY_W-1:0] xs, ys, x_nx, y_nx;
        logic signed [Z_W-1:0]  z_nx;

        always_comb
        begin
            xs = cx_reg[i] >>> i;
            ys = cy_reg[i] >>> i;
            if (!cy_reg[i][XY_W-1])
            begin
                x_nx = cx_reg[i] + ys;
                y_nx = cy_reg[i] - xs;
                z_nx = cz_reg[i] + atan_entry(i);
            end
            else
            begin
                x_nx = cx_reg[i] - ys;
                y_nx = cy_reg[i] + xs;
                z_nx = cz_reg[i] - atan_entry(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[i+1] <= x_nx;
                cy_reg[i+1] <= y_nx;
                cz_reg[i+1] <= z_nx;
                cs_reg[i+1] <= cs_reg[i];
            end
        end
    end

    // |z| plus half an output LSB
    assign absz_next = (cz_reg[NSTG][Z_W-1] ? Z_W'(-cz_reg[NSTG]) : Z_W'(cz_reg[NSTG]))
                       + Z_W'(ROUND_HALF);

    // Scale, saturate, take the sign of the cross product; override special cases
    always_comb
    begin
        rq       = absz_reg[Z_W-1:ROUND_SHIFT];
        mag_sat  = (rq > RQ_W'(OUT_PI)) ? ANGLE_PI : ANGLE_W'(rq);
        res_next.zero_len = sr1_reg.zero_len;
        if (sr1_reg.zero_len)
        begin
            res_next.angle = '0;
        end
        else if (sr1_reg.cross_zero)
        begin
            res_next.angle = sr1_reg.dot_neg ? ANGLE_PI : '0;
        end
        else
        begin
            res_next.angle = sr1_reg.cross_neg ? -mag_sat : mag_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr1_reg  <= cs_reg[NSTG];
            absz_reg <= absz_next;
            res_reg  <= res_next;
        end
    end

    assign out_valid = vr2_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[design/signed_angle_between_vectors_top.sv]
// Path from accepted request to m_axis_tvalid:
//   six normalization stages, one pre-rotation stage, one stage per CORDIC iteration,
//   two rounding stages, then a two-entry output buffer.
// Throughput: one request per cycle; the pipeline halts only while the output buffer is full.
// Reset (rst_n low, asynchronous) clears all valid bits and the buffer count; no other state.
`default_nettype none
`include "assert_macros.svh"

module signed_angle_between_vectors_top #(
    parameter int COORD_WIDTH   = sabv_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = sabv_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // first_x, first_y, second_x, second_y, zero padding
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // angle
    output logic [sabv_pkg::ANGLE_W-1:0]            m_axis_tdata,
    // zero_length
    output logic                                    m_axis_tuser
);
    import sabv_pkg::*;

    localparam logic [1:0] BUF_FULL = 2'd2;

    logic                          en;
    logic                          norm_valid, pipe_valid;
    logic signed [NORM_W-1:0]      x_n, y_n;
    side_t                         norm_side;
    result_t                       pipe_res;
    logic signed [COORD_WIDTH-1:0] first_x, first_y, second_x, second_y;

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot1_reg;
    logic       push, pop;

    // Unpack the request
    assign first_x  = s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    assign first_y  = s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    assign second_x = s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign second_y = s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH];

    // Whole pipeline advances while the output buffer has room
    assign en            = (cnt_reg != BUF_FULL);
    assign s_axis_tready = en;

    sabv_norm #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .first_x   (first_x),
        .first_y   (first_y),
        .second_x  (second_x),
        .second_y  (second_y),
        .out_valid (norm_valid),
        .x_n       (x_n),
        .y_n       (y_n),
        .side      (norm_side)
    );

    sabv_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (norm_valid),
        .x_n       (x_n),
        .y_n       (y_n),
        .side      (norm_side),
        .out_valid (pipe_valid),
        .res       (pipe_res)
    );

    // Two-entry output buffer, slot0 is presented
    assign push     = pipe_valid && en;
    assign pop      = m_axis_tvalid && m_axis_tready;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (cnt_reg == BUF_FULL))
        begin
            slot0_reg <= slot1_reg;
        end
        else if (push && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop)))
        begin
            slot0_reg <= pipe_res;
        end
        if (push && (cnt_reg == 2'd1) && !pop)
        begin
            slot1_reg <= pipe_res;
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = slot0_reg.angle;
    assign m_axis_tuser  = slot0_reg.zero_len;

    // Checks
    `SABV_ASSERT_IMPL(a_zero_len_angle, m_axis_tvalid && m_axis_tuser, slot0_reg.angle == '0, "zero-length result carries a nonzero angle")
    `SABV_ASSERT_IMPL(a_angle_range, m_axis_tvalid, (slot0_reg.angle <= ANGLE_PI) && (slot0_reg.angle >= ANGLE_NEG_PI), "angle outside [-pi, pi]")
    `SABV_ASSERT_NEXT(a_pipe_hold, pipe_valid && !en, pipe_valid, "stalled pipeline lost its last item")
    `SABV_ASSERT_NEXT(a_full_hold, (cnt_reg == BUF_FULL) && !m_axis_tready, cnt_reg == BUF_FULL, "output buffer count changed without a pop")

endmodule

`default_nettype wire
